[hdl/spm_pkg.sv]
`timescale 1ns / 1ps

package spm_pkg;

    localparam int MAX_PATTERN_DEFAULT = 32;
    localparam int INDEX_BITS_DEFAULT  = 16;

    // Register file geometry
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int PAT_CHARS    = 32;
    localparam int PAT_WORDS    = 4;
    localparam int LEN_W        = 6;
    localparam int START_W      = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS_3 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_INDEX     = 3'd5;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd1;

    typedef struct packed {
        logic [PAT_CHARS*8-1:0] pattern_chars;   // char 0 in low byte
        logic [LEN_W-1:0]       pattern_length;
        logic [START_W-1:0]     start_index;
    } cfg_t;

endpackage

[hdl/spm_cfg_regs.sv]
`timescale 1ns / 1ps

module spm_cfg_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]        cfg_wr_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
    output spm_pkg::cfg_t                          cfg
);

    spm_pkg::cfg_t cfg_reg;
    spm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                spm_pkg::REG_PATTERN_LENGTH:
                    cfg_next.pattern_length = cfg_wr_data[spm_pkg::LEN_W-1:0];
                spm_pkg::REG_PATTERN_CHARS_0:
                    cfg_next.pattern_chars[0*64 +: 64] = cfg_wr_data;
                spm_pkg::REG_PATTERN_CHARS_1:
                    cfg_next.pattern_chars[1*64 +: 64] = cfg_wr_data;
                spm_pkg::REG_PATTERN_CHARS_2:
                    cfg_next.pattern_chars[2*64 +: 64] = cfg_wr_data;
                spm_pkg::REG_PATTERN_CHARS_3:
                    cfg_next.pattern_chars[3*64 +: 64] = cfg_wr_data;
                spm_pkg::REG_START_INDEX:
                    cfg_next.start_index = cfg_wr_data[spm_pkg::START_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_chars  <= '0;
            cfg_reg.pattern_length <= spm_pkg::PATTERN_LENGTH_RESET;
            cfg_reg.start_index    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/spm_match.sv]
`timescale 1ns / 1ps

// Parallel compare of the configured pattern against the window that ends
// at the current byte. Window byte d is the byte d steps back (0 = current).
module spm_match #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEFAULT,
    parameter int INDEX_BITS  = spm_pkg::INDEX_BITS_DEFAULT
) (
    input  spm_pkg::cfg_t              cfg,
    input  logic [MAX_PATTERN*8-1:0]   window,
    input  logic [INDEX_BITS-1:0]      pos,
    output logic                       found,
    output logic [INDEX_BITS-1:0]      match_start
);

    localparam int LW = 8;  // holds lengths up to 64 and their shifts
    localparam int CW = (INDEX_BITS > spm_pkg::START_W) ? INDEX_BITS : spm_pkg::START_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    logic [MAX_PATTERN*8-1:0] rev_pat;
    logic [MAX_PATTERN*8-1:0] aligned;
    logic [LW-1:0]            len;
    logic [LW-1:0]            len_m1;
    logic [LW-1:0]            shift;
    logic [MAX_PATTERN-1:0]   eq;
    logic [INDEX_BITS-1:0]    begin_pos;
    logic                     in_text;
    logic                     after_start;

    // Pattern reversed: rev_pat byte k holds pattern char MAX_PATTERN-1-k.
    // Chars past the register file read as zero.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_rev
        if (MAX_PATTERN - 1 - k < spm_pkg::PAT_CHARS) begin : g_char
            assign rev_pat[k*8 +: 8] = cfg.pattern_chars[(MAX_PATTERN-1-k)*8 +: 8];
        end else begin : g_zero
            assign rev_pat[k*8 +: 8] = 8'h00;
        end
    end

    always_comb begin
        len = {{(LW-spm_pkg::LEN_W){1'b0}}, cfg.pattern_length};
        if (len == '0) begin
            len = LW'(1);
        end else if (len > MAX_LEN) begin
            len = MAX_LEN;
        end
        len_m1 = len - LW'(1);
        shift  = MAX_LEN - len;
    end

    // Byte d of aligned is pattern char len-1-d.
    assign aligned = rev_pat >> {shift, 3'b000};

    for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cmp
        assign eq[d] = (LW'(d) >= len) || (aligned[d*8 +: 8] == window[d*8 +: 8]);
    end

    assign in_text     = pos >= INDEX_BITS'(len_m1);
    assign begin_pos   = pos - INDEX_BITS'(len_m1);
    assign after_start = CW'(begin_pos) >= CW'(cfg.start_index);

    assign found       = in_text && after_start && (&eq);
    assign match_start = found ? begin_pos : '0;

endmodule

[hdl/spm_track.sv]
`timescale 1ns / 1ps

// Byte history shift line and saturating text position.
module spm_track #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEFAULT,
    parameter int INDEX_BITS  = spm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [7:0]                 cur_byte,
    input  logic                       first,
    output logic [MAX_PATTERN*8-1:0]   window,
    output logic [INDEX_BITS-1:0]      pos,
    output logic                       sat_after
);

    localparam int HIST_DEPTH = MAX_PATTERN - 1;

    logic [7:0]            hist_reg [HIST_DEPTH];
    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] pos_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic                  sat_eff;

    // History left by an earlier text never reaches a compare: the
    // position guard keeps the window inside the current text.
    always_comb begin
        window[7:0] = cur_byte;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            window[(k+1)*8 +: 8] = hist_reg[k];
        end
    end

    always_comb begin
        pos     = first ? '0 : pos_reg;
        sat_eff = first ? 1'b0 : sat_reg;
        if (pos == '1) begin
            pos_next = pos;
            sat_next = 1'b1;
        end else begin
            pos_next = pos + INDEX_BITS'(1);
            sat_next = sat_eff;
        end
    end

    assign sat_after = sat_next;

    always_ff @(posedge aclk) begin
        if (advance) begin
            hist_reg[0] <= cur_byte;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sat_reg <= 1'b0;
        end else if (advance) begin
            pos_reg <= pos_next;
            sat_reg <= sat_next;
        end
    end

endmodule

[hdl/streaming_pattern_matcher.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_text_byte[7:0], s_first_of_text
// m_        out  m_valid/m_ready    m_match_found, m_match_start, m_index_overflow
// cfg_      in   cfg_wr_en          cfg_wr_index[2:0], cfg_wr_data[63:0]
//
// One item in, one result out, one item per cycle sustained while m_ready is held high.
// Each item passes through the input register, then the compare into the result register.
// The whole-window compare is a single level of byte compares and an AND tree.
// Synchronous active-low reset clears valids, text position, overflow flag
// and config (length set to 1); a stalled result holds and input fills behind it.
module streaming_pattern_matcher #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEFAULT,
    parameter int INDEX_BITS  = spm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_text_byte,
    input  logic                               s_first_of_text,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_match_found,
    output logic [INDEX_BITS-1:0]              m_match_start,
    output logic                               m_index_overflow,

    input  logic                               cfg_wr_en,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    spm_pkg::cfg_t cfg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [INDEX_BITS-1:0] out_start_reg;
    logic                  out_ovf_reg;

    logic                     advance;
    logic [MAX_PATTERN*8-1:0] window;
    logic [INDEX_BITS-1:0]    pos;
    logic                     sat_after;
    logic                     found;
    logic [INDEX_BITS-1:0]    match_start;

    // The held item moves into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    spm_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    spm_track #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cur_byte  (in_byte_reg),
        .first     (in_first_reg),
        .window    (window),
        .pos       (pos),
        .sat_after (sat_after)
    );

    spm_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_match (
        .cfg         (cfg),
        .window      (window),
        .pos         (pos),
        .found       (found),
        .match_start (match_start)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_first_reg <= s_first_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_found_reg <= found;
            out_start_reg <= match_start;
            out_ovf_reg   <= sat_after;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_match_found    = out_found_reg;
    assign m_match_start    = out_start_reg;
    assign m_index_overflow = out_ovf_reg;

endmodule
